// ===== hdl/assert_macros.svh =====
// Assertion macros used by the file that checks the calibrator's logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition that must hold in the same cycle as its trigger.
`define DCTC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks a condition that must hold in the cycle after its trigger.
`define DCTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/dctc_pkg.sv =====
// Shared types, codes and defaults of the tare calibrator.
package dctc_pkg;

    localparam int DEF_SAMPLE_COUNT = 20;
    localparam int DEF_CHANNELS     = 2;
    localparam int DEF_SAMPLE_BITS  = 24;

    localparam logic [31:0] WATCHDOG_RESET = 32'd3000000;

    localparam int SAMPLE_W = 24;
    localparam int TARED_W  = 25;
    localparam int OFFSET_W = 24;
    localparam int STATUS_W = 2;
    localparam int LIMIT_W  = 32;
    localparam int COUNT_W  = 8;

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 3;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_NORMAL = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CAL    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FAILED = 2'd2;

    typedef struct packed {
        logic                action;
        logic                channel;
        logic [SAMPLE_W-1:0] sample;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]        status;
        logic                       reading_valid;
        logic signed [TARED_W-1:0]  tared_reading;
        logic signed [OFFSET_W-1:0] channel_offset;
    } result_t;

endpackage

// ===== hdl/dctc_in_reg.sv =====
// Input register: holds one accepted item until the core consumes it.
module dctc_in_reg (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  dctc_pkg::item_t item_in,
    input  logic           take,
    output logic           item_vld,
    output dctc_pkg::item_t item_out
);
    import dctc_pkg::*;

    logic  vld_reg;
    logic  vld_next;
    item_t item_reg;

    // A new item may enter when the register is empty or is drained this cycle.
    assign s_tready = !vld_reg || take;
    assign vld_next = (s_tvalid && s_tready) || (vld_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= item_in;
        end
    end

    assign item_vld = vld_reg;
    assign item_out = item_reg;

endmodule

// ===== hdl/dctc_core.sv =====
// Calibration state, offset computation and result formation for one item per cycle while take is high.
module dctc_core #(
    parameter int SAMPLE_COUNT = dctc_pkg::DEF_SAMPLE_COUNT,
    parameter int CHANNELS     = dctc_pkg::DEF_CHANNELS,
    parameter int SAMPLE_BITS  = dctc_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [dctc_pkg::LIMIT_W-1:0]  cfg_wr_data,
    input  logic                          take,
    input  dctc_pkg::item_t               item,
    output dctc_pkg::result_t             res,
    output logic [dctc_pkg::STATUS_W-1:0] cur_mode
);
    import dctc_pkg::*;

    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SUM_W   = SAMPLE_BITS + COUNT_W;
    localparam int NB      = SUM_W - 1;
    localparam int DIV_L   = $clog2(SAMPLE_COUNT);
    localparam int DIV_SH  = NB + DIV_L;
    localparam int DIV_MW  = NB + 1;
    localparam int PROD_W  = NB + DIV_MW;
    localparam logic [63:0] DIV_NUM = 64'd1 << DIV_SH;
    // Reciprocal of the sample count, rounded up, exact for NB-bit magnitudes.
    localparam logic [DIV_MW-1:0] DIV_M =
        DIV_MW'((DIV_NUM + 64'(SAMPLE_COUNT) - 64'd1) / 64'(SAMPLE_COUNT));

    typedef enum logic [STATUS_W-1:0] {
        MODE_NORMAL = STATUS_NORMAL,
        MODE_CAL    = STATUS_CAL,
        MODE_FAILED = STATUS_FAILED
    } mode_t;

    mode_t                         mode_reg;
    mode_t                         mode_next;
    logic [LIMIT_W-1:0]            limit_reg;
    logic [LIMIT_W-1:0]            ticks_reg;
    logic [LIMIT_W-1:0]            ticks_next;
    logic [LIMIT_W-1:0]            ticks_inc;
    logic signed [SUM_W-1:0]       sum_reg  [CHANNELS];
    logic signed [SUM_W-1:0]       sum_next [CHANNELS];
    logic [COUNT_W-1:0]            cnt_reg  [CHANNELS];
    logic [COUNT_W-1:0]            cnt_next [CHANNELS];
    logic [CHANNELS-1:0]           done_reg;
    logic [CHANNELS-1:0]           done_next;
    logic signed [SAMPLE_BITS-1:0] off_reg  [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] off_next [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] raw_reg  [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] raw_next [CHANNELS];

    logic                          present;
    logic [CH_W-1:0]               ch_idx;
    logic signed [SAMPLE_BITS-1:0] smp;
    logic signed [SUM_W-1:0]       sum_add;
    logic signed [SUM_W-1:0]       sum_neg;
    logic [COUNT_W:0]              cnt_inc;
    logic [NB-1:0]                 div_mag;
    logic [PROD_W-1:0]             div_prod;
    logic [SAMPLE_BITS-1:0]        div_q;
    logic signed [SAMPLE_BITS-1:0] div_off;
    logic signed [SAMPLE_BITS-1:0] off_sel;
    logic signed [SAMPLE_BITS-1:0] raw_sel;
    logic signed [TARED_W-1:0]     tared;

    assign present = int'(item.channel) < CHANNELS;
    assign ch_idx  = CH_W'(item.channel);
    assign smp     = $signed(item.sample[SAMPLE_BITS-1:0]);
    assign sum_add = sum_reg[ch_idx] + SUM_W'(smp);
    assign sum_neg = -sum_add;
    assign cnt_inc = {1'b0, cnt_reg[ch_idx]} + (COUNT_W + 1)'(1);

    // Truncating division of the finished sum by the sample count: magnitude
    // times the reciprocal, then the sign is put back.
    assign div_mag  = sum_add[SUM_W-1] ? NB'(sum_neg) : NB'(sum_add);
    assign div_prod = PROD_W'(div_mag) * PROD_W'(DIV_M);
    assign div_q    = div_prod[DIV_SH +: SAMPLE_BITS];
    assign div_off  = sum_add[SUM_W-1] ? $signed(-div_q) : $signed(div_q);

    assign ticks_inc = (&ticks_reg) ? ticks_reg : ticks_reg + LIMIT_W'(1);

    always_comb
    begin
        mode_next  = mode_reg;
        ticks_next = ticks_reg;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        done_next  = done_reg;
        off_next   = off_reg;
        raw_next   = raw_reg;
        if (item.action == ACT_SAMPLE)
        begin
            if (present)
            begin
                unique case (mode_reg)
                    MODE_CAL:
                    begin
                        if (!done_reg[ch_idx])
                        begin
                            sum_next[ch_idx] = sum_add;
                            cnt_next[ch_idx] = cnt_inc[COUNT_W-1:0];
                            if (cnt_inc >= (COUNT_W + 1)'(SAMPLE_COUNT))
                            begin
                                off_next[ch_idx]  = div_off;
                                done_next[ch_idx] = 1'b1;
                            end
                            // Seed the raw readings so the first tared reading is zero.
                            if (&done_next)
                            begin
                                raw_next  = off_next;
                                mode_next = MODE_NORMAL;
                            end
                        end
                    end
                    MODE_NORMAL:
                    begin
                        raw_next[ch_idx] = smp;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        else if (mode_reg == MODE_CAL)
        begin
            ticks_next = ticks_inc;
            if (ticks_inc >= limit_reg)
            begin
                mode_next = MODE_FAILED;
            end
        end
    end

    assign off_sel = present ? off_next[ch_idx] : '0;
    assign raw_sel = present ? raw_next[ch_idx] : '0;
    assign tared   = TARED_W'(raw_sel) - TARED_W'(off_sel);

    always_comb
    begin
        res.status         = mode_next;
        res.reading_valid  = present && (mode_next == MODE_NORMAL);
        res.tared_reading  = res.reading_valid ? tared : '0;
        res.channel_offset = OFFSET_W'(off_sel);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_CAL;
            limit_reg <= WATCHDOG_RESET;
            ticks_reg <= '0;
            done_reg  <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                sum_reg[i] <= '0;
                cnt_reg[i] <= '0;
                off_reg[i] <= '0;
                raw_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            if (take)
            begin
                mode_reg  <= mode_next;
                ticks_reg <= ticks_next;
                done_reg  <= done_next;
                sum_reg   <= sum_next;
                cnt_reg   <= cnt_next;
                off_reg   <= off_next;
                raw_reg   <= raw_next;
            end
        end
    end

    assign cur_mode = mode_reg;

endmodule

// ===== hdl/dctc_out_reg.sv =====
// Result register: holds one result until the downstream side takes it.
module dctc_out_reg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  dctc_pkg::result_t              res,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dctc_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [dctc_pkg::M_TUSER_W-1:0] m_tuser
);
    import dctc_pkg::*;

    localparam int PAD_W = M_TDATA_W - TARED_W - OFFSET_W;

    logic    vld_reg;
    logic    vld_next;
    result_t res_reg;

    assign vld_next = load || (vld_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = {PAD_W'(0), res_reg.channel_offset, res_reg.tared_reading};
    assign m_tuser  = {res_reg.reading_valid, res_reg.status};

endmodule

// ===== hdl/dual_channel_tare_calibrator.sv =====
// Top level of the two-channel tare calibrator.
//
// The block takes one item per clock while the output is not stalled: an
// input register, the logic that updates the calibration state, and a
// result register; a result is offered once its item has passed the state
// update into the result register and leaves when m_axis_tready is high.
// s_axis_tready follows m_axis_tready combinationally. After reset each
// channel averages its first SAMPLE_COUNT samples into an offset (rounded
// toward zero); when every channel is done the status turns normal and
// tared readings start at zero. Ticks count against the watchdog limit
// (cfg_wr_data, written with cfg_wr_en while idle); reaching it during
// calibration fails the block for good.
`include "assert_macros.svh"

module dual_channel_tare_calibrator #(
    parameter int SAMPLE_COUNT = dctc_pkg::DEF_SAMPLE_COUNT,
    parameter int CHANNELS     = dctc_pkg::DEF_CHANNELS,
    parameter int SAMPLE_BITS  = dctc_pkg::DEF_SAMPLE_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // sample
    input  logic [dctc_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // action, channel
    input  logic [dctc_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tared_reading, channel_offset, zero padding
    output logic [dctc_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // status, reading_valid
    output logic [dctc_pkg::M_TUSER_W-1:0] m_axis_tuser,
    input  logic                           cfg_wr_en,
    input  logic [dctc_pkg::LIMIT_W-1:0]   cfg_wr_data
);
    import dctc_pkg::*;

    item_t               item_in;
    item_t               item;
    logic                item_vld;
    logic                take;
    result_t             res;
    logic [STATUS_W-1:0] cur_mode;
    logic                mode_failed;
    logic                mode_normal;
    logic                mode_cal;
    logic                out_stall;
    logic                out_invalid;
    logic                tared_zero;

    assign item_in.action  = s_axis_tuser[0];
    assign item_in.channel = s_axis_tuser[1];
    assign item_in.sample  = s_axis_tdata;

    // The held item is processed whenever the result register can accept it.
    assign take = item_vld && (!m_axis_tvalid || m_axis_tready);

    dctc_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .item_in  (item_in),
        .take     (take),
        .item_vld (item_vld),
        .item_out (item)
    );

    dctc_core #(
        .SAMPLE_COUNT (SAMPLE_COUNT),
        .CHANNELS     (CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .take        (take),
        .item        (item),
        .res         (res),
        .cur_mode    (cur_mode)
    );

    dctc_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (take),
        .res      (res),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tuser  (m_axis_tuser)
    );

    assign mode_failed = (cur_mode == STATUS_FAILED);
    assign mode_normal = (cur_mode == STATUS_NORMAL);
    assign mode_cal    = (cur_mode == STATUS_CAL);
    assign out_stall   = item_vld && m_axis_tvalid && !m_axis_tready;
    assign out_invalid = m_axis_tvalid && !m_axis_tuser[STATUS_W];
    assign tared_zero  = (m_axis_tdata[TARED_W-1:0] == '0);

    `DCTC_ASSERT_NEXT(a_failed_terminal, clk, rst_n, mode_failed, mode_failed, "failed mode left")
    `DCTC_ASSERT_NEXT(a_no_recalibration, clk, rst_n, mode_normal, !mode_cal, "calibration reentered")
    `DCTC_ASSERT_NOW(a_stall_blocks_input, clk, rst_n, out_stall, !s_axis_tready, "taken in stall")
    `DCTC_ASSERT_NOW(a_tared_zero_when_invalid, clk, rst_n, out_invalid, tared_zero, "tared not zero")

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking stream testbench for the two-channel tare calibrator.
module tb_top;
    import dctc_pkg::*;

    localparam int CAL_SAMPLES   = DEF_SAMPLE_COUNT;
    localparam int NUM_CHANNELS  = DEF_CHANNELS;
    localparam int STALL_LIMIT   = 5000;
    localparam int LONG_HOLD     = 300;
    localparam int SEGMENT_ITEMS = 200;
    localparam int SEGMENTS      = 8;
    localparam int MAX_PRINTS    = 40;

    class tare_tracker;
        logic [STATUS_W-1:0] mode;
        logic [LIMIT_W-1:0]  limit;
        logic [LIMIT_W-1:0]  ticks;
        int                  sum [NUM_CHANNELS];
        int                  count [NUM_CHANNELS];
        bit                  ch_done [NUM_CHANNELS];
        int                  offset [NUM_CHANNELS];
        int                  raw [NUM_CHANNELS];
        result_t             reading_q[$];
        int                  errors;

        function new();
            mode   = STATUS_CAL;
            limit  = WATCHDOG_RESET;
            ticks  = '0;
            errors = 0;
            foreach (sum[i])
            begin
                sum[i]     = 0;
                count[i]   = 0;
                ch_done[i] = 1'b0;
                offset[i]  = 0;
                raw[i]     = 0;
            end
        endfunction

        function void set_limit(input logic [LIMIT_W-1:0] value);
            limit = value;
        endfunction

        // Applies one accepted transfer to the calibration state and queues the reading.
        function void take_item(input item_t it);
            int      smp;
            int      ch;
            int      diff;
            bit      all_done;
            result_t want;
            smp = {{(32 - SAMPLE_W){it.sample[SAMPLE_W-1]}}, it.sample};
            ch  = int'(it.channel);
            if (it.action == ACT_SAMPLE)
            begin
                if (mode == STATUS_CAL && !ch_done[ch])
                begin
                    sum[ch] += smp;
                    count[ch]++;
                    if (count[ch] >= CAL_SAMPLES)
                    begin
                        // Integer division of ints truncates toward zero.
                        offset[ch]  = sum[ch] / count[ch];
                        ch_done[ch] = 1'b1;
                    end
                    all_done = 1'b1;
                    foreach (ch_done[i])
                        if (!ch_done[i])
                            all_done = 1'b0;
                    if (all_done)
                    begin
                        foreach (raw[i])
                            raw[i] = offset[i];
                        mode = STATUS_NORMAL;
                    end
                end
                else if (mode == STATUS_NORMAL)
                begin
                    raw[ch] = smp;
                end
            end
            else if (mode == STATUS_CAL)
            begin
                if (ticks != '1)
                    ticks++;
                if (ticks >= limit)
                    mode = STATUS_FAILED;
            end
            diff = raw[ch] - offset[ch];
            want.status         = mode;
            want.reading_valid  = (mode == STATUS_NORMAL);
            want.tared_reading  = (mode == STATUS_NORMAL) ? diff[TARED_W-1:0] : '0;
            want.channel_offset = offset[ch][OFFSET_W-1:0];
            reading_q.push_back(want);
        endfunction

        task report_mismatch(input string msg);
            if (errors < MAX_PRINTS)
                $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(input result_t got);
            result_t want;
            if (reading_q.size() == 0)
            begin
                report_mismatch("result transfer with no reading outstanding");
                return;
            end
            want = reading_q.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
            if (got.reading_valid !== want.reading_valid)
                report_mismatch($sformatf("reading_valid got %0b want %0b",
                                          got.reading_valid, want.reading_valid));
            if (got.tared_reading !== want.tared_reading)
                report_mismatch($sformatf("tared_reading got %0d want %0d",
                                          got.tared_reading, want.tared_reading));
            if (got.channel_offset !== want.channel_offset)
                report_mismatch($sformatf("channel_offset got %0d want %0d",
                                          got.channel_offset, want.channel_offset));
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [S_TUSER_W-1:0] s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;
    logic                 cfg_wr_en;
    logic [LIMIT_W-1:0]   cfg_wr_data;

    tare_tracker tracker;
    bit          steady;
    bit          hold_req;
    result_t     seen;

    dual_channel_tare_calibrator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 24'h7F_FFFF;
        if (r == 1)
            return 24'h80_0000;
        // Small values around zero make sums whose truncation direction matters.
        if (r < 4)
            return SAMPLE_W'($urandom_range(0, 64)) - 24'd32;
        return SAMPLE_W'($urandom);
    endfunction

    function automatic item_t make_item(input logic action, input logic channel,
                                        input logic [SAMPLE_W-1:0] sample);
        item_t it;
        it.action  = action;
        it.channel = channel;
        it.sample  = sample;
        return it;
    endfunction

    function automatic item_t random_item(input int tick_odds);
        logic action;
        action = ($urandom_range(1, tick_odds) == 1) ? ACT_TICK : ACT_SAMPLE;
        return make_item(action, 1'($urandom_range(0, 1)), rand_sample());
    endfunction

    task automatic send_item(input item_t it);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= it.sample;
        s_axis_tuser  <= {it.channel, it.action};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        tracker.take_item(it);
    endtask

    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (tracker.reading_q.size() != 0)
            @(posedge clk);
    endtask

    // Every transfer yields a result, so an empty queue means the block is idle.
    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        drain();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        tracker.set_limit(value);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen.status         = m_axis_tuser[STATUS_W-1:0];
            seen.reading_valid  = m_axis_tuser[STATUS_W];
            seen.tared_reading  = m_axis_tdata[TARED_W-1:0];
            seen.channel_offset = m_axis_tdata[TARED_W+OFFSET_W-1:TARED_W];
            tracker.check_result(seen);
        end
    end

    initial
    begin : result_sink
        int stall;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                hold_req = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            stall = steady ? 0 : pick_gap();
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin : stimulus
        bit               fail_path;
        logic [LIMIT_W-1:0] next_limit;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        steady        = 1'b0;
        hold_req      = 1'b0;
        tracker       = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_limit(32'hFFFF_FFFF);
        // Ticks while calibrating, one carrying sample bits that must be ignored.
        send_item(make_item(ACT_TICK, 1'b0, 24'h00_0000));
        send_item(make_item(ACT_TICK, 1'b1, 24'hFF_FFFF));
        send_item(make_item(ACT_SAMPLE, 1'b0, 24'h7F_FFFF));
        send_item(make_item(ACT_SAMPLE, 1'b0, 24'h80_0000));
        send_item(make_item(ACT_SAMPLE, 1'b0, 24'h00_0000));
        send_item(make_item(ACT_SAMPLE, 1'b0, 24'hFF_FFFF));
        send_item(make_item(ACT_SAMPLE, 1'b0, 24'h7F_FFFF));
        send_item(make_item(ACT_SAMPLE, 1'b1, 24'h80_0000));
        send_item(make_item(ACT_SAMPLE, 1'b1, 24'h80_0000));
        send_item(make_item(ACT_SAMPLE, 1'b1, 24'h55_5555));
        send_item(make_item(ACT_SAMPLE, 1'b1, 24'hAA_AAAA));
        // Tiny limits are harmless as long as no tick follows them.
        write_limit(32'd0);
        send_item(make_item(ACT_SAMPLE, 1'b0, 24'h00_0001));
        send_item(make_item(ACT_SAMPLE, 1'b1, 24'h7F_FFFE));
        write_limit(32'd1);
        send_item(make_item(ACT_SAMPLE, 1'b0, 24'h80_0001));
        send_item(make_item(ACT_SAMPLE, 1'b1, 24'hFF_FFFE));

        // Failure is terminal, so the seed picks which end state this run explores.
        fail_path = ($urandom_range(0, 3) == 0);
        if (fail_path)
        begin
            write_limit(32'($urandom_range(0, 1)));
            while (!tracker.ch_done[0])
                send_item(make_item(ACT_SAMPLE, 1'b0, rand_sample()));
            send_item(make_item(ACT_SAMPLE, 1'b0, rand_sample()));
            send_item(make_item(ACT_SAMPLE, 1'b1, rand_sample()));
            send_item(make_item(ACT_TICK, 1'b1, rand_sample()));
        end
        else
        begin
            write_limit(32'($urandom_range(32'd10000, 32'hFFFF_FFFE)));
            while (tracker.mode == STATUS_CAL)
                send_item(random_item(8));
        end

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg > 0)
            begin
                case (seg)
                    1:       next_limit = 32'd0;
                    2:       next_limit = 32'd1;
                    3:       next_limit = 32'hFFFF_FFFF;
                    default: next_limit = $urandom;
                endcase
                write_limit(next_limit);
            end
            steady   = (seg == 3);
            hold_req = (seg == 5);
            repeat (SEGMENT_ITEMS)
                send_item(random_item(6));
        end
        steady = 1'b0;

        drain();
        repeat (5) @(posedge clk);
        if (tracker.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== dual_channel_tare_calibrator.f =====
+incdir+hdl
hdl/dctc_pkg.sv
hdl/dctc_in_reg.sv
hdl/dctc_core.sv
hdl/dctc_out_reg.sv
hdl/dual_channel_tare_calibrator.sv
verif/tb_top.sv
